// ===== rtl/core/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg
// shared sizes, command codes and the control word broadcast to the cell row
// ----------------------------------------------------------------------------
package iirl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 15;   // magnitude bits of the signed position

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic               rd_en;
      logic [IDX_W-1:0]   pos;
      logic [DATA_W-1:0]  value;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/indexed_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// ordered list of signed 32-bit words with insert, remove, get and clear by index
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one word per cell, each wired to
// its two neighbors. An add opens a gap by moving every cell above the
// position up by one; a remove closes the gap the same way, and the block
// takes one command per cycle for as long as the result side keeps up.
// Each command gives exactly one result word in the cycle after it is
// accepted; it is held in an output register, and a new command is taken
// in the same cycle the held result is taken. A negative position is
// rejected (status 1) before the full check of an add; an add at or past
// the count appends. Remove and get past the end answer status 1 and
// change nothing. Clear always succeeds. Entries above the count are
// never read, so the cells need no clearing after reset.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list
   import iirl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [47:0]   req_tdata,    // position[15:0], value[47:16]
   input  logic [1:0]    req_tuser,    // cmd[1:0]

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,    // placed_index[5:0], read_value[37:6],
                                       // count[44:38], zero[47:45]
   output logic [1:0]    rsp_tuser     // status[1:0]
);

   // input word fields
   logic [1:0]         cmd;
   logic               pos_neg;
   logic [POS_W-1:0]   pos_mag;
   logic [DATA_W-1:0]  value;
   logic               accept;

   // list length and result register
   logic [CNT_W-1:0]   count_ff,      count_in;
   logic               rsp_valid_ff;
   logic [1:0]         status_ff,     status_in;
   logic [IDX_W-1:0]   placed_ff,     placed_in;
   logic [DATA_W-1:0]  read_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   logic               past_end;
   logic               full;
   cell_ctrl_type      ctrl;
   logic [DATA_W-1:0]  rd_data;

   assign cmd     = req_tuser;
   assign pos_neg = req_tdata[15];
   assign pos_mag = req_tdata[14:0];
   assign value   = req_tdata[47:16];

   // take a new word whenever the result register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign past_end = pos_mag >= POS_W'(count_ff);
   assign full     = count_ff == CNT_W'(CAPACITY);

   // command decode: result fields, new count and the cell row's control word
   always_comb begin
      status_in  = ST_OK;
      placed_in  = '0;
      count_in   = count_ff;
      ctrl.op    = OP_HOLD;
      ctrl.rd_en = 1'b0;
      ctrl.pos   = pos_mag[IDX_W-1:0];
      ctrl.value = value;
      case (cmd)
         CMD_ADD: begin
            if (pos_neg) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               // append lands at the current count
               if (past_end) begin
                  ctrl.pos = count_ff[IDX_W-1:0];
               end
               placed_in = ctrl.pos;
               ctrl.op   = OP_INSERT;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (pos_neg || past_end) begin
               status_in = ST_RANGE;
            end else begin
               ctrl.op  = OP_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_GET: begin
            if (pos_neg || past_end) begin
               status_in = ST_RANGE;
            end else begin
               ctrl.rd_en = 1'b1;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      // nothing moves unless a word is really taken
      if (!accept) begin
         ctrl.op    = OP_HOLD;
         ctrl.rd_en = 1'b0;
      end
   end

   iirl_row u_row (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         placed_ff    <= placed_in;
         read_ff      <= rd_data;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tuser        = status_ff;
   assign rsp_tdata[5:0]   = 6'(placed_ff);
   assign rsp_tdata[37:6]  = read_ff;
   assign rsp_tdata[44:38] = 7'(rsp_count_ff);
   assign rsp_tdata[47:45] = 3'b000;

endmodule

// ===== rtl/core/iirl_cell.sv =====
// ----------------------------------------------------------------------------
// iirl_cell
// one list slot: holds, takes from its left or right neighbor, or loads a new word
// ----------------------------------------------------------------------------
module iirl_cell
   import iirl_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_idx,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]   data_out,
   output logic [DATA_W-1:0]   rd_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (cell_idx == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (cell_idx > ctrl.pos) begin
               data_in = left_data;
            end
         end
         OP_REMOVE: begin
            if (cell_idx >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // gated so the row can or all cells together
   assign rd_out = (ctrl.rd_en && (cell_idx == ctrl.pos)) ? data_ff : '0;

endmodule

// ===== rtl/core/iirl_row.sv =====
// ----------------------------------------------------------------------------
// iirl_row
// row of list cells chained to their neighbors, with the get read-out
// ----------------------------------------------------------------------------
module iirl_row
   import iirl_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   output logic [DATA_W-1:0]   rd_data
);

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_rd   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end

      iirl_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   // at most one cell drives a nonzero word
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | cell_rd[i];
      end
   end

endmodule

// ===== tb/sv/tb_indexed_insert_remove_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list
// self-checking bench for the indexed insert/remove list
// ----------------------------------------------------------------------------
// A shadow copy of the list predicts status, placed index, read word and count
// for every accepted command word; each response word is checked in order.
// A short directed run covers empty, negative, append and edge positions,
// then random blocks fill, drain and churn the list under random gaps and
// back-pressure, with one long stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list
   import iirl_pkg::*;
();

   localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int BLOCK_ITEMS  = 100;
   localparam int RANDOM_BLOCKS = 11;

   // expected response fields
   typedef struct {
      logic [1:0]        status;
      logic [IDX_W-1:0]  placed;
      logic [DATA_W-1:0] read_word;
      logic [CNT_W-1:0]  count;
   } answer_type;

   // command mixes for the random blocks
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN,
      MIX_CHURN
   } cmd_mix_type;

   // shadow list: predicts each answer and checks the block's answers in order
   class shadow_list_type;
      logic [DATA_W-1:0] cells [CAPACITY];
      int unsigned       fill;
      answer_type        pending_answers [$];
      int unsigned       mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      // work out the answer to an accepted command and update the shadow
      function void note_command(logic [1:0] cmd, logic [15:0] pos,
                                 logic [DATA_W-1:0] word);
         answer_type  a;
         int unsigned mag;
         a.status    = ST_OK;
         a.placed    = '0;
         a.read_word = '0;
         mag = {17'd0, pos[14:0]};
         case (cmd)
            CMD_ADD: begin
               // negative check comes before the full check
               if (pos[15]) begin
                  a.status = ST_RANGE;
               end else if (fill >= CAPACITY) begin
                  a.status = ST_FULL;
               end else if (mag >= fill) begin
                  cells[fill] = word;
                  a.placed = IDX_W'(fill);
                  fill++;
               end else begin
                  for (int i = fill; i > mag; i--) cells[i] = cells[i-1];
                  cells[mag] = word;
                  a.placed = IDX_W'(mag);
                  fill++;
               end
            end
            CMD_REMOVE: begin
               if (pos[15] || mag >= fill) begin
                  a.status = ST_RANGE;
               end else begin
                  for (int i = mag; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            CMD_GET: begin
               if (pos[15] || mag >= fill) a.status = ST_RANGE;
               else a.read_word = cells[mag];
            end
            default: begin
               fill = 0;
            end
         endcase
         a.count = CNT_W'(fill);
         pending_answers.push_back(a);
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      // compare one response word with the oldest expectation
      task check_answer(logic [1:0] status, logic [47:0] word);
         answer_type e;
         if (pending_answers.size() == 0) begin
            report("response word with nothing expected");
            return;
         end
         e = pending_answers.pop_front();
         if (status !== e.status)
            report($sformatf("status %0d, expected %0d", status, e.status));
         if (word[5:0] !== e.placed)
            report($sformatf("placed_index %0d, expected %0d", word[5:0], e.placed));
         if (word[37:6] !== e.read_word)
            report($sformatf("read_value %h, expected %h", word[37:6], e.read_word));
         if (word[44:38] !== e.count)
            report($sformatf("count %0d, expected %0d", word[44:38], e.count));
         if (word[47:45] !== 3'b000)
            report($sformatf("padding bits %b not zero", word[47:45]));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // position[15:0], value[47:16]
   logic [1:0]  req_tuser  = CMD_GET;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // placed_index[5:0], read_value[37:6],
                                   // count[44:38], zero[47:45]
   logic [1:0]  rsp_tuser;         // status[1:0]

   bit          gaps_on   = 1'b1;  // random idling on the command side
   bit          stalls_on = 1'b1;  // random back-pressure on the response side
   int unsigned quiet_cycles = 0;

   shadow_list_type sb = new();

   indexed_insert_remove_list dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // present one command word and hold it until it is taken
   task send_command(logic [1:0] cmd, logic [15:0] pos, logic [DATA_W-1:0] word);
      if (gaps_on && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {word, pos};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, pos, word);
   endtask

   // pick a position: mostly inside or just past the list, some far and negative
   function logic [15:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 16'($urandom_range(0, sb.fill));
      if (roll < 80) return 16'($urandom_range(sb.fill, 32767));
      if (roll < 90) return {1'b1, 15'($urandom)};
      return 16'($urandom);
   endfunction

   function logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // pick a command according to the mix of the current block
   function logic [1:0] pick_command(cmd_mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 85) return CMD_ADD;
            if (roll < 90) return CMD_REMOVE;
            return CMD_GET;
         end
         MIX_DRAIN: begin
            if (roll < 20) return CMD_ADD;
            if (roll < 75) return CMD_REMOVE;
            return CMD_GET;
         end
         MIX_EVEN: begin
            if (roll < 40) return CMD_ADD;
            if (roll < 70) return CMD_REMOVE;
            if (roll < 98) return CMD_GET;
            return CMD_CLEAR;
         end
         default: begin
            if (roll < 35) return CMD_ADD;
            if (roll < 60) return CMD_REMOVE;
            if (roll < 90) return CMD_GET;
            return CMD_CLEAR;
         end
      endcase
   endfunction

   // response side: check on each handshake, then choose the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_answer(rsp_tuser, rsp_tdata);
      rsp_tready <= !(stalls_on && $urandom_range(0, 99) < 17);
   end

   // watchdog: count cycles in which no word moves on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // stimulus
   initial begin
      cmd_mix_type mix;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, negative positions, append, front and middle insert
      send_command(CMD_GET,    16'd0,     32'd0);
      send_command(CMD_REMOVE, 16'd0,     32'd0);
      send_command(CMD_ADD,    16'h8000,  32'h1234_5678);   // most negative position
      send_command(CMD_ADD,    16'd0,     32'h7fff_ffff);
      send_command(CMD_ADD,    16'd32767, 32'h8000_0000);   // far past the end appends
      send_command(CMD_ADD,    16'd0,     32'hffff_ffff);   // insert at the front
      send_command(CMD_ADD,    16'd1,     32'h0000_0000);   // insert in the middle
      send_command(CMD_GET,    16'd0,     32'd0);
      send_command(CMD_GET,    16'd1,     32'd0);
      send_command(CMD_GET,    16'd2,     32'd0);
      send_command(CMD_GET,    16'd3,     32'd0);
      send_command(CMD_GET,    16'd4,     32'd0);            // one past the end
      send_command(CMD_GET,    16'hffff,  32'd0);
      send_command(CMD_REMOVE, 16'hffff,  32'd0);
      send_command(CMD_REMOVE, 16'd3,     32'd0);            // last entry
      send_command(CMD_REMOVE, 16'd0,     32'd0);            // first entry
      send_command(CMD_REMOVE, 16'd99,    32'd0);
      send_command(CMD_GET,    16'd1,     32'd0);
      send_command(CMD_CLEAR,  16'hffff,  32'hffff_ffff);
      send_command(CMD_CLEAR,  16'd0,     32'd0);            // clear when empty
      send_command(CMD_ADD,    16'd5,     32'h5a5a_a5a5);    // append into empty list
      send_command(CMD_GET,    16'd0,     32'd0);

      // random blocks; the first one fills the list up to capacity and beyond
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         mix = (b == 0) ? MIX_FILL : cmd_mix_type'($urandom_range(0, 3));
         // two blocks at full rate on both sides
         gaps_on   = !(b == 4 || b == 5);
         stalls_on = gaps_on;
         for (int n = 0; n < BLOCK_ITEMS; n++)
            send_command(pick_command(mix), pick_position(), pick_word());
      end
      req_tvalid <= 1'b0;

      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/iirl_pkg.sv
rtl/core/iirl_cell.sv
rtl/core/iirl_row.sv
rtl/core/indexed_insert_remove_list.sv
tb/sv/tb_indexed_insert_remove_list.sv
